FILE: src/stft_pkg.sv
// ----------------------------------------------------------------------------
// stft_pkg
// shared types, codes and constants of the sip transaction table
// ----------------------------------------------------------------------------
`default_nettype none

package stft_pkg;

    localparam int unsigned TABLE_SLOTS_DEF = 256;

    // request kinds
    localparam logic [1:0] ACT_REQ   = 2'd0;
    localparam logic [1:0] ACT_RESP  = 2'd1;
    localparam logic [1:0] ACT_TIMER = 2'd2;

    // methods
    localparam logic [1:0] M_INVITE = 2'd0;
    localparam logic [1:0] M_ACK    = 2'd1;
    localparam logic [1:0] M_CANCEL = 2'd2;

    // phases
    localparam logic [2:0] PH_CALLING    = 3'd0;
    localparam logic [2:0] PH_TRYING     = 3'd1;
    localparam logic [2:0] PH_PROCEEDING = 3'd2;
    localparam logic [2:0] PH_COMPLETED  = 3'd3;
    localparam logic [2:0] PH_CONFIRMED  = 3'd4;
    localparam logic [2:0] PH_TERMINATED = 3'd5;

    // machine kinds
    localparam logic [2:0] MK_CNI   = 3'd0;
    localparam logic [2:0] MK_CI    = 3'd1;
    localparam logic [2:0] MK_SNI   = 3'd2;
    localparam logic [2:0] MK_SI    = 3'd3;
    localparam logic [2:0] MK_STALE = 3'd4;

    // timer kinds
    localparam logic [3:0] TK_TRYING = 4'd0;
    localparam logic [3:0] TK_A      = 4'd1;
    localparam logic [3:0] TK_B      = 4'd2;
    localparam logic [3:0] TK_D      = 4'd3;
    localparam logic [3:0] TK_E1     = 4'd4;
    localparam logic [3:0] TK_E2     = 4'd5;
    localparam logic [3:0] TK_F      = 4'd6;
    localparam logic [3:0] TK_G      = 4'd7;
    localparam logic [3:0] TK_H      = 4'd8;
    localparam logic [3:0] TK_I      = 4'd9;
    localparam logic [3:0] TK_J      = 4'd10;
    localparam logic [3:0] TK_K      = 4'd11;
    localparam logic [3:0] TK_STALE  = 4'd12;

    // wire and user actions
    localparam logic [1:0] WA_NONE   = 2'd0;
    localparam logic [1:0] WA_SEND   = 2'd1;
    localparam logic [1:0] WA_RESEND = 2'd2;
    localparam logic [1:0] WA_ACK    = 2'd3;
    localparam logic [1:0] UA_NONE   = 2'd0;
    localparam logic [1:0] UA_PASS   = 2'd1;
    localparam logic [1:0] UA_SAVED  = 2'd2;

    // status code bounds
    localparam logic [9:0] CODE_PROV  = 10'd100;
    localparam logic [9:0] CODE_OK    = 10'd200;
    localparam logic [9:0] CODE_FAIL  = 10'd300;
    localparam logic [9:0] CODE_MAX   = 10'd699;

    // configuration register indexes
    localparam logic [3:0] CFG_T1      = 4'd0;
    localparam logic [3:0] CFG_T2      = 4'd1;
    localparam logic [3:0] CFG_T4      = 4'd2;
    localparam logic [3:0] CFG_TD      = 4'd3;
    localparam logic [3:0] CFG_TS      = 4'd4;
    localparam logic [3:0] CFG_T100    = 4'd5;
    localparam logic [3:0] CFG_DISCARD = 4'd6;
    localparam logic [3:0] CFG_RELIABLE = 4'd7;

    typedef struct packed {
        logic [13:0] t1;
        logic [15:0] t2;
        logic [15:0] t4;
        logic [19:0] td;
        logic [19:0] ts;
        logic [15:0] t100;
        logic        discard;
        logic        reliable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  slot;
        logic        slot_known;
        logic [1:0]  method;
        logic [1:0]  cseq_method;
        logic [9:0]  status_code;
        logic        from_user;
        logic [3:0]  timer_kind;
        logic [19:0] timer_delay;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [2:0] phase;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0]  wire_a;
        logic [1:0]  user_a;
        logic [3:0]  tk0;
        logic [19:0] td0;
        logic [3:0]  tk1;
        logic [19:0] td1;
        logic        rel;
        logic        err;
    } res_t;

endpackage

`default_nettype wire

FILE: src/stft_ram.sv
// ----------------------------------------------------------------------------
// stft_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module stft_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/stft_front.sv
// ----------------------------------------------------------------------------
// stft_front
// accepts requests, clears the table after reset, reads the slot entry,
// classifies the request and queues it for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module stft_front
    import stft_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire item_t                          in_item,
    // queue towards the back end
    output logic                                q_valid,
    output item_t                               q_item,
    output entry_t                              q_entry,
    output logic                                q_hit,
    output logic                                q_in_range,
    output logic [$clog2(TABLE_SLOTS)-1:0]      q_addr,
    input  wire logic                           q_pop,
    // write from the back end
    input  wire logic                           bk_we,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0] bk_addr,
    input  wire entry_t                         bk_data
);

    localparam int unsigned AW = $clog2(TABLE_SLOTS);

    logic [AW:0]   clr_cnt_reg;
    logic          clearing;
    logic          busy_reg;
    logic          pend_reg;
    item_t         item_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic          we;
    logic [ENTRY_W-1:0] rdata;
    entry_t        rentry;
    logic [AW+7:0] slot_ext;
    logic          in_range;
    logic          accept;

    assign clearing = (clr_cnt_reg < (AW+1)'(TABLE_SLOTS));
    assign in_ready = !clearing && !busy_reg;
    assign accept   = in_valid && in_ready;

    // address from the held request, or from the new one on accept
    always_comb
    begin
        if (accept)
        begin
            slot_ext = {{AW{1'b0}}, in_item.slot};
        end
        else
        begin
            slot_ext = {{AW{1'b0}}, item_reg.slot};
        end
    end
    assign raddr    = slot_ext[AW-1:0];
    assign in_range = (slot_ext < (AW+8)'(TABLE_SLOTS));

    assign we    = clearing || bk_we;
    assign waddr = clearing ? clr_cnt_reg[AW-1:0] : bk_addr;
    assign wdata = clearing ? entry_t'('0) : bk_data;

    stft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rentry = entry_t'(rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            q_valid     <= 1'b0;
        end
        else
        begin
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
                pend_reg <= 1'b1;
            end
            else if (pend_reg)
            begin
                pend_reg <= 1'b0;
                q_valid  <= 1'b1;
            end
            else if (q_pop)
            begin
                q_valid  <= 1'b0;
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        if (pend_reg)
        begin
            q_item     <= item_reg;
            q_entry    <= rentry;
            q_in_range <= in_range;
            q_hit      <= in_range && item_reg.slot_known && rentry.valid;
            q_addr     <= raddr;
        end
    end

endmodule

`default_nettype wire

FILE: src/stft_back.sv
// ----------------------------------------------------------------------------
// stft_back
// runs the transaction machines, writes the entry back and holds the result
// ----------------------------------------------------------------------------
`default_nettype none

module stft_back
    import stft_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cfg_t                           cfg,
    input  wire logic                           q_valid,
    input  wire item_t                          q_item,
    input  wire entry_t                         q_entry,
    input  wire logic                           q_hit,
    input  wire logic                           q_in_range,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0] q_addr,
    output logic                                q_pop,
    output logic                                bk_we,
    output logic [$clog2(TABLE_SLOTS)-1:0]      bk_addr,
    output entry_t                              bk_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          wire_action,
    output logic [1:0]                          user_action,
    output logic [3:0]                          first_timer,
    output logic [19:0]                         first_delay,
    output logic [3:0]                          second_timer,
    output logic [19:0]                         second_delay,
    output logic                                release_slot,
    output logic                                dropped,
    output logic                                protocol_error,
    output logic [2:0]                          phase_after
);

    function automatic res_t add_timer(res_t r, logic [3:0] kind, logic [19:0] dly);
        res_t o;
        o = r;
        if (r.tk0 == 4'd0)
        begin
            o.tk0 = kind + 4'd1;
            o.td0 = dly;
        end
        else
        begin
            o.tk1 = kind + 4'd1;
            o.td1 = dly;
        end
        return o;
    endfunction

    res_t        r;
    logic [2:0]  k;
    logic [2:0]  p;
    logic        have;
    logic        created;
    logic        quiet;
    logic        early;
    logic [19:0] long_wait;
    logic [19:0] backoff;
    logic [1:0]  act;
    logic [1:0]  meth;
    logic [9:0]  code;
    logic        fu;
    logic [3:0]  tk;

    assign act  = q_item.action;
    assign meth = q_item.method;
    assign code = q_item.status_code;
    assign fu   = q_item.from_user;
    assign tk   = q_item.timer_kind;

    assign long_wait = {cfg.t1, 6'b0};
    assign backoff   = (q_item.timer_delay < {4'd0, cfg.t2}) ?
                       {q_item.timer_delay[18:0], 1'b0} : q_item.timer_delay;
    assign early     = (q_entry.phase == PH_TRYING) || (q_entry.phase == PH_PROCEEDING);

    always_comb
    begin
        r       = '0;
        k       = MK_CNI;
        p       = PH_TERMINATED;
        have    = 1'b0;
        created = 1'b0;
        if (q_in_range)
        begin
            if (q_hit)
            begin
                have = 1'b1;
                k    = q_entry.kind;
                p    = q_entry.phase;
                case (q_entry.kind)
                    MK_CNI:
                    begin
                        if (act == ACT_REQ)
                        begin
                            if (meth != M_INVITE && fu)
                            begin
                                r = add_timer(r, TK_F, long_wait);
                                r.wire_a = WA_SEND;
                            end
                        end
                        else if (act == ACT_RESP)
                        begin
                            if (!fu && code >= CODE_PROV && code < CODE_OK)
                            begin
                                if (p == PH_TRYING || p == PH_PROCEEDING)
                                begin
                                    p = PH_PROCEEDING;
                                    if (!cfg.reliable)
                                    begin
                                        r = add_timer(r, TK_E2, {4'd0, cfg.t2});
                                    end
                                    r.user_a = UA_PASS;
                                end
                            end
                            else if (!fu && code >= CODE_OK)
                            begin
                                r.user_a = UA_PASS;
                                if (cfg.reliable)
                                begin
                                    r.rel = 1'b1;
                                end
                                else
                                begin
                                    p = PH_COMPLETED;
                                    r = add_timer(r, TK_K, {4'd0, cfg.t4});
                                end
                            end
                        end
                        else if (act == ACT_TIMER)
                        begin
                            if (tk == TK_E1)
                            begin
                                if (p == PH_TRYING)
                                begin
                                    r = add_timer(r, TK_E1, backoff);
                                    r.wire_a = WA_RESEND;
                                end
                            end
                            else if (tk == TK_E2)
                            begin
                                if (p == PH_PROCEEDING)
                                begin
                                    r = add_timer(r, TK_E2, {4'd0, cfg.t2});
                                    r.wire_a = WA_RESEND;
                                end
                            end
                            else if (tk == TK_F)
                            begin
                                r.user_a = UA_SAVED;
                                r.rel    = 1'b1;
                            end
                            else if (tk == TK_K)
                            begin
                                r.rel = 1'b1;
                            end
                            else
                            begin
                                r.err = 1'b1;
                            end
                        end
                    end
                    MK_CI:
                    begin
                        if (act == ACT_REQ)
                        begin
                            if (meth == M_INVITE && fu)
                            begin
                                r = add_timer(r, TK_B, long_wait);
                                r.wire_a = WA_SEND;
                            end
                        end
                        else if (act == ACT_RESP)
                        begin
                            if (!fu && q_item.cseq_method == M_INVITE)
                            begin
                                if (code >= CODE_PROV && code < CODE_OK)
                                begin
                                    if (p == PH_CALLING || p == PH_PROCEEDING)
                                    begin
                                        p = PH_PROCEEDING;
                                        r.user_a = UA_PASS;
                                    end
                                end
                                else if (code >= CODE_OK && code < CODE_FAIL)
                                begin
                                    k = MK_STALE;
                                    p = PH_TERMINATED;
                                    r = add_timer(r, TK_STALE, cfg.ts);
                                    r.user_a = UA_PASS;
                                end
                                else if (code >= CODE_FAIL)
                                begin
                                    if (cfg.reliable)
                                    begin
                                        r.wire_a = WA_ACK;
                                        r.user_a = UA_PASS;
                                        r.rel    = 1'b1;
                                    end
                                    else if (p == PH_CALLING || p == PH_PROCEEDING)
                                    begin
                                        p = PH_COMPLETED;
                                        r = add_timer(r, TK_D, cfg.td);
                                        r.wire_a = WA_ACK;
                                        r.user_a = UA_PASS;
                                    end
                                    else if (p == PH_COMPLETED)
                                    begin
                                        r.wire_a = WA_RESEND;
                                        r.user_a = UA_PASS;
                                    end
                                    else
                                    begin
                                        r.err = 1'b1;
                                    end
                                end
                            end
                        end
                        else if (act == ACT_TIMER)
                        begin
                            if (tk == TK_A)
                            begin
                                if (p == PH_CALLING)
                                begin
                                    r = add_timer(r, TK_A, backoff);
                                    r.wire_a = WA_RESEND;
                                end
                            end
                            else if (tk == TK_B)
                            begin
                                r.rel = 1'b1;
                                r.err = 1'b1;
                            end
                            else if (tk == TK_D)
                            begin
                                r.rel = 1'b1;
                            end
                        end
                    end
                    MK_SNI:
                    begin
                        if (act == ACT_REQ)
                        begin
                            if (meth != M_INVITE && !fu && p != PH_TRYING)
                            begin
                                if (p == PH_PROCEEDING || p == PH_COMPLETED)
                                begin
                                    r.wire_a = WA_RESEND;
                                end
                                else
                                begin
                                    r.err = 1'b1;
                                end
                            end
                        end
                        else if (act == ACT_RESP)
                        begin
                            if (fu && code >= CODE_PROV && code < CODE_OK)
                            begin
                                if (p == PH_TRYING || p == PH_PROCEEDING)
                                begin
                                    p = PH_PROCEEDING;
                                    r.wire_a = WA_SEND;
                                end
                            end
                            else if (fu && code >= CODE_OK && code <= CODE_MAX)
                            begin
                                if (cfg.reliable)
                                begin
                                    r.wire_a = WA_SEND;
                                    r.rel    = 1'b1;
                                end
                                else if (p == PH_TRYING || p == PH_PROCEEDING)
                                begin
                                    p = PH_COMPLETED;
                                    r = add_timer(r, TK_J, long_wait);
                                    r.wire_a = WA_SEND;
                                end
                                else if (p != PH_COMPLETED)
                                begin
                                    r.err = 1'b1;
                                end
                            end
                        end
                        else if (act == ACT_TIMER)
                        begin
                            if (tk == TK_J && p == PH_COMPLETED)
                            begin
                                r.rel = 1'b1;
                            end
                            else
                            begin
                                r.err = 1'b1;
                            end
                        end
                    end
                    MK_SI:
                    begin
                        if (act == ACT_REQ)
                        begin
                            if (!fu)
                            begin
                                if (meth == M_INVITE)
                                begin
                                    if (p == PH_PROCEEDING || p == PH_COMPLETED)
                                    begin
                                        r.user_a = UA_PASS;
                                    end
                                end
                                else if (meth == M_ACK)
                                begin
                                    if (p == PH_COMPLETED)
                                    begin
                                        if (cfg.reliable)
                                        begin
                                            r.rel = 1'b1;
                                        end
                                        else
                                        begin
                                            p = PH_CONFIRMED;
                                            r = add_timer(r, TK_I, {4'd0, cfg.t4});
                                        end
                                    end
                                end
                                else if (meth == M_CANCEL)
                                begin
                                    r.user_a = UA_PASS;
                                end
                            end
                        end
                        else if (act == ACT_RESP)
                        begin
                            if (fu && code >= CODE_PROV && code <= CODE_MAX
                                && q_item.cseq_method == M_INVITE)
                            begin
                                if (code == CODE_PROV)
                                begin
                                    if (p == PH_TRYING)
                                    begin
                                        p = PH_PROCEEDING;
                                        r.wire_a = WA_SEND;
                                    end
                                end
                                else if (code < CODE_OK)
                                begin
                                    if (early)
                                    begin
                                        p = PH_PROCEEDING;
                                        r.wire_a = WA_SEND;
                                    end
                                end
                                else if (code < CODE_FAIL)
                                begin
                                    if (early)
                                    begin
                                        k = MK_STALE;
                                        p = PH_TERMINATED;
                                        r = add_timer(r, TK_STALE, cfg.ts);
                                        r.wire_a = WA_SEND;
                                    end
                                end
                                else if (early)
                                begin
                                    p = PH_COMPLETED;
                                    r = add_timer(r, TK_H, long_wait);
                                    if (!cfg.reliable)
                                    begin
                                        r = add_timer(r, TK_G, {6'd0, cfg.t1});
                                    end
                                    r.wire_a = WA_SEND;
                                end
                            end
                        end
                        else if (act == ACT_TIMER)
                        begin
                            if (tk == TK_G)
                            begin
                                if (p == PH_COMPLETED)
                                begin
                                    r.wire_a = WA_RESEND;
                                    r = add_timer(r, TK_G, backoff);
                                end
                            end
                            else if (tk == TK_H || tk == TK_I)
                            begin
                                r.rel = 1'b1;
                            end
                            else if (tk == TK_J)
                            begin
                                r.rel = 1'b0;
                            end
                            else if (tk == TK_TRYING)
                            begin
                                if (p == PH_TRYING)
                                begin
                                    r.wire_a = WA_RESEND;
                                end
                            end
                            else
                            begin
                                r.err = 1'b1;
                            end
                        end
                    end
                    MK_STALE:
                    begin
                        if (act == ACT_TIMER && tk == TK_STALE)
                        begin
                            r.rel = 1'b1;
                        end
                    end
                    default:
                    begin
                        r.err = 1'b1;
                    end
                endcase
            end
            else if (act == ACT_REQ)
            begin
                have    = 1'b1;
                created = 1'b1;
                if (!fu)
                begin
                    if (meth == M_INVITE)
                    begin
                        k = MK_SI;
                        p = PH_PROCEEDING;
                        r = add_timer(r, TK_TRYING, {4'd0, cfg.t100});
                    end
                    else
                    begin
                        k = MK_SNI;
                        p = PH_TRYING;
                    end
                    r.user_a = UA_PASS;
                end
                else if (meth == M_INVITE)
                begin
                    k = MK_CI;
                    p = PH_CALLING;
                    r = add_timer(r, TK_B, long_wait);
                    r.wire_a = WA_SEND;
                end
                else
                begin
                    k = MK_CNI;
                    p = PH_TRYING;
                    r = add_timer(r, TK_F, long_wait);
                    r.wire_a = WA_SEND;
                end
            end
            else if (act == ACT_RESP && !cfg.discard)
            begin
                r.err = 1'b1;
            end
        end
        quiet = (r.wire_a == WA_NONE) && (r.user_a == UA_NONE) && (r.tk0 == 4'd0)
                && !r.rel && !r.err && !created
                && (!have || created || (k == q_entry.kind && p == q_entry.phase));
    end

    assign q_pop         = q_valid && (!out_valid || out_ready);
    assign bk_we         = q_pop && have;
    assign bk_addr       = q_addr;
    assign bk_data.valid = !r.rel;
    assign bk_data.kind  = k;
    assign bk_data.phase = r.rel ? PH_TERMINATED : p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            wire_action    <= r.wire_a;
            user_action    <= r.user_a;
            first_timer    <= r.tk0;
            first_delay    <= r.td0;
            second_timer   <= r.tk1;
            second_delay   <= r.td1;
            release_slot   <= r.rel;
            dropped        <= quiet;
            protocol_error <= r.err;
            phase_after    <= (have && !r.rel) ? p : PH_TERMINATED;
        end
    end

endmodule

`default_nettype wire

FILE: src/sip_transaction_fsm_table_core.sv
// ----------------------------------------------------------------------------
// sip_transaction_fsm_table_core
// table of sip client and server transaction machines
// ----------------------------------------------------------------------------
// each request carries a sip request, a sip response or a timer expiry for one
// slot of the transaction table and yields exactly one result: what goes to
// the wire and to the transaction user, up to two timers to start with their
// delays, whether the slot is freed, and the phase left behind. requests are
// handled one at a time; a result is offered once its request has gone through
// the table read with the request capture, then the queue stage, then the
// machine update that writes the entry back and loads the result register in
// the same edge. the next request is taken once the previous one has written
// its entry back, and the machine update waits while the result side holds
// off an earlier result. after reset the table is swept clear, one slot a
// cycle, over all TABLE_SLOTS slots, during which no request is taken;
// configuration writes are taken at any time but are meant to land while the
// block is idle
// ----------------------------------------------------------------------------
`default_nettype none

module sip_transaction_fsm_table_core
    import stft_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    // request channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  slot,
    input  wire logic        slot_known,
    input  wire logic [1:0]  method,
    input  wire logic [1:0]  cseq_method,
    input  wire logic [9:0]  status_code,
    input  wire logic        from_user,
    input  wire logic [3:0]  timer_kind,
    input  wire logic [19:0] timer_delay,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       wire_action,
    output logic [1:0]       user_action,
    output logic [3:0]       first_timer,
    output logic [19:0]      first_delay,
    output logic [3:0]       second_timer,
    output logic [19:0]      second_delay,
    output logic             release_slot,
    output logic             dropped,
    output logic             protocol_error,
    output logic [2:0]       phase_after
);

    localparam int unsigned AW = $clog2(TABLE_SLOTS);

    cfg_t          cfg_reg;
    item_t         in_item;
    logic          q_valid;
    item_t         q_item;
    entry_t        q_entry;
    logic          q_hit;
    logic          q_in_range;
    logic [AW-1:0] q_addr;
    logic          q_pop;
    logic          bk_we;
    logic [AW-1:0] bk_addr;
    entry_t        bk_data;

    // timer and mode registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.t1       <= 14'd500;
            cfg_reg.t2       <= 16'd4000;
            cfg_reg.t4       <= 16'd5000;
            cfg_reg.td       <= 20'd32000;
            cfg_reg.ts       <= 20'd32000;
            cfg_reg.t100     <= 16'd200;
            cfg_reg.discard  <= 1'b1;
            cfg_reg.reliable <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_T1:       cfg_reg.t1       <= cfg_data[13:0];
                CFG_T2:       cfg_reg.t2       <= cfg_data[15:0];
                CFG_T4:       cfg_reg.t4       <= cfg_data[15:0];
                CFG_TD:       cfg_reg.td       <= cfg_data;
                CFG_TS:       cfg_reg.ts       <= cfg_data;
                CFG_T100:     cfg_reg.t100     <= cfg_data[15:0];
                CFG_DISCARD:  cfg_reg.discard  <= cfg_data[0];
                CFG_RELIABLE: cfg_reg.reliable <= cfg_data[0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // request fields gathered into one bundle
    assign in_item.action      = action;
    assign in_item.slot        = slot;
    assign in_item.slot_known  = slot_known;
    assign in_item.method      = method;
    assign in_item.cseq_method = cseq_method;
    assign in_item.status_code = status_code;
    assign in_item.from_user   = from_user;
    assign in_item.timer_kind  = timer_kind;
    assign in_item.timer_delay = timer_delay;

    // front end: acceptance, table sweep, entry read and classification
    stft_front #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_entry    (q_entry),
        .q_hit      (q_hit),
        .q_in_range (q_in_range),
        .q_addr     (q_addr),
        .q_pop      (q_pop),
        .bk_we      (bk_we),
        .bk_addr    (bk_addr),
        .bk_data    (bk_data)
    );

    // back end: machine update, write-back and result register
    stft_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_entry        (q_entry),
        .q_hit          (q_hit),
        .q_in_range     (q_in_range),
        .q_addr         (q_addr),
        .q_pop          (q_pop),
        .bk_we          (bk_we),
        .bk_addr        (bk_addr),
        .bk_data        (bk_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .wire_action    (wire_action),
        .user_action    (user_action),
        .first_timer    (first_timer),
        .first_delay    (first_delay),
        .second_timer   (second_timer),
        .second_delay   (second_delay),
        .release_slot   (release_slot),
        .dropped        (dropped),
        .protocol_error (protocol_error),
        .phase_after    (phase_after)
    );

endmodule

`default_nettype wire

FILE: dv/stft_result_checker.sv
// ----------------------------------------------------------------------------
// stft_result_checker
// watches the request, result and configuration channels of the transaction
// table, predicts each result from its own copy of the table and compares
// ----------------------------------------------------------------------------
module stft_result_checker
    import stft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  slot,
    input  logic        slot_known,
    input  logic [1:0]  method,
    input  logic [1:0]  cseq_method,
    input  logic [9:0]  status_code,
    input  logic        from_user,
    input  logic [3:0]  timer_kind,
    input  logic [19:0] timer_delay,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  wire_action,
    input  logic [1:0]  user_action,
    input  logic [3:0]  first_timer,
    input  logic [19:0] first_delay,
    input  logic [3:0]  second_timer,
    input  logic [19:0] second_delay,
    input  logic        release_slot,
    input  logic        dropped,
    input  logic        protocol_error,
    input  logic [2:0]  phase_after,
    output int          fail_count,
    output int          awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  wire_a;
        logic [1:0]  user_a;
        logic [3:0]  tk0;
        logic [19:0] td0;
        logic [3:0]  tk1;
        logic [19:0] td1;
        logic        rel;
        logic        drop;
        logic        err;
        logic [2:0]  ph;
    } outcome_t;

    // mirror of the timer settings
    logic [13:0] t1;
    logic [15:0] t2, t4, t100;
    logic [19:0] td, ts;
    logic        discard, reliable;

    // mirror of the transaction table
    logic [2:0] ent_kind  [256];
    logic [2:0] ent_phase [256];
    logic       ent_valid [256];

    outcome_t outcome_q[$];

    function automatic void arm(inout outcome_t o, input logic [3:0] k,
                                input logic [31:0] d);
        if (o.tk0 == 4'd0)
        begin
            o.tk0 = k + 4'd1;
            o.td0 = d[19:0];
        end
        else
        begin
            o.tk1 = k + 4'd1;
            o.td1 = d[19:0];
        end
    endfunction

    function automatic logic [31:0] grow(input logic [31:0] d);
        return (d < 32'(t2)) ? d * 2 : d;
    endfunction

    function automatic void client_ni(inout outcome_t o, inout logic [2:0] p,
                                      input item_t it);
        logic [31:0] lw;
        lw = 64 * 32'(t1);
        case (it.action)
            ACT_REQ:
                if (it.method != M_INVITE && it.from_user)
                begin
                    arm(o, TK_F, lw);
                    o.wire_a = WA_SEND;
                end
            ACT_RESP:
                if (!it.from_user)
                begin
                    if (it.status_code >= CODE_PROV && it.status_code < CODE_OK)
                    begin
                        if (p == PH_TRYING || p == PH_PROCEEDING)
                        begin
                            p = PH_PROCEEDING;
                            if (!reliable) arm(o, TK_E2, 32'(t2));
                            o.user_a = UA_PASS;
                        end
                    end
                    else if (it.status_code >= CODE_OK)
                    begin
                        o.user_a = UA_PASS;
                        if (reliable) o.rel = 1'b1;
                        else
                        begin
                            p = PH_COMPLETED;
                            arm(o, TK_K, 32'(t4));
                        end
                    end
                end
            ACT_TIMER:
                case (it.timer_kind)
                    TK_E1:
                        if (p == PH_TRYING)
                        begin
                            arm(o, TK_E1, grow(32'(it.timer_delay)));
                            o.wire_a = WA_RESEND;
                        end
                    TK_E2:
                        if (p == PH_PROCEEDING)
                        begin
                            arm(o, TK_E2, 32'(t2));
                            o.wire_a = WA_RESEND;
                        end
                    TK_F:
                    begin
                        o.user_a = UA_SAVED;
                        o.rel = 1'b1;
                    end
                    TK_K: o.rel = 1'b1;
                    default: o.err = 1'b1;
                endcase
            default: ;
        endcase
    endfunction

    function automatic void client_inv(inout outcome_t o, inout logic [2:0] k,
                                       inout logic [2:0] p, input item_t it);
        logic [31:0] lw;
        lw = 64 * 32'(t1);
        case (it.action)
            ACT_REQ:
                if (it.method == M_INVITE && it.from_user)
                begin
                    arm(o, TK_B, lw);
                    o.wire_a = WA_SEND;
                end
            ACT_RESP:
                if (!it.from_user && it.cseq_method == M_INVITE)
                begin
                    if (it.status_code >= CODE_PROV && it.status_code < CODE_OK)
                    begin
                        if (p == PH_CALLING || p == PH_PROCEEDING)
                        begin
                            p = PH_PROCEEDING;
                            o.user_a = UA_PASS;
                        end
                    end
                    else if (it.status_code >= CODE_OK && it.status_code < CODE_FAIL)
                    begin
                        k = MK_STALE;
                        p = PH_TERMINATED;
                        arm(o, TK_STALE, 32'(ts));
                        o.user_a = UA_PASS;
                    end
                    else if (it.status_code >= CODE_FAIL)
                    begin
                        if (reliable)
                        begin
                            o.wire_a = WA_ACK;
                            o.user_a = UA_PASS;
                            o.rel = 1'b1;
                        end
                        else if (p == PH_CALLING || p == PH_PROCEEDING)
                        begin
                            p = PH_COMPLETED;
                            arm(o, TK_D, 32'(td));
                            o.wire_a = WA_ACK;
                            o.user_a = UA_PASS;
                        end
                        else if (p == PH_COMPLETED)
                        begin
                            o.wire_a = WA_RESEND;
                            o.user_a = UA_PASS;
                        end
                        else o.err = 1'b1;
                    end
                end
            ACT_TIMER:
                case (it.timer_kind)
                    TK_A:
                        if (p == PH_CALLING)
                        begin
                            arm(o, TK_A, grow(32'(it.timer_delay)));
                            o.wire_a = WA_RESEND;
                        end
                    TK_B:
                    begin
                        o.rel = 1'b1;
                        o.err = 1'b1;
                    end
                    TK_D: o.rel = 1'b1;
                    default: ;
                endcase
            default: ;
        endcase
    endfunction

    function automatic void server_ni(inout outcome_t o, inout logic [2:0] p,
                                      input item_t it);
        case (it.action)
            ACT_REQ:
                if (it.method != M_INVITE && !it.from_user && p != PH_TRYING)
                begin
                    if (p == PH_PROCEEDING || p == PH_COMPLETED) o.wire_a = WA_RESEND;
                    else o.err = 1'b1;
                end
            ACT_RESP:
                if (it.from_user)
                begin
                    if (it.status_code >= CODE_PROV && it.status_code < CODE_OK)
                    begin
                        if (p == PH_TRYING || p == PH_PROCEEDING)
                        begin
                            p = PH_PROCEEDING;
                            o.wire_a = WA_SEND;
                        end
                    end
                    else if (it.status_code >= CODE_OK && it.status_code <= CODE_MAX)
                    begin
                        if (reliable)
                        begin
                            o.wire_a = WA_SEND;
                            o.rel = 1'b1;
                        end
                        else if (p == PH_TRYING || p == PH_PROCEEDING)
                        begin
                            p = PH_COMPLETED;
                            arm(o, TK_J, 64 * 32'(t1));
                            o.wire_a = WA_SEND;
                        end
                        else if (p != PH_COMPLETED) o.err = 1'b1;
                    end
                end
            ACT_TIMER:
                if (it.timer_kind == TK_J && p == PH_COMPLETED) o.rel = 1'b1;
                else o.err = 1'b1;
            default: ;
        endcase
    endfunction

    function automatic void server_inv(inout outcome_t o, inout logic [2:0] k,
                                       inout logic [2:0] p, input item_t it);
        logic early;
        early = (p == PH_TRYING || p == PH_PROCEEDING);
        case (it.action)
            ACT_REQ:
                if (!it.from_user)
                begin
                    if (it.method == M_INVITE)
                    begin
                        if (p == PH_PROCEEDING || p == PH_COMPLETED) o.user_a = UA_PASS;
                    end
                    else if (it.method == M_ACK)
                    begin
                        if (p == PH_COMPLETED)
                        begin
                            if (reliable) o.rel = 1'b1;
                            else
                            begin
                                p = PH_CONFIRMED;
                                arm(o, TK_I, 32'(t4));
                            end
                        end
                    end
                    else if (it.method == M_CANCEL) o.user_a = UA_PASS;
                end
            ACT_RESP:
                if (it.from_user && it.status_code >= CODE_PROV
                    && it.status_code <= CODE_MAX && it.cseq_method == M_INVITE)
                begin
                    if (it.status_code == CODE_PROV)
                    begin
                        if (p == PH_TRYING)
                        begin
                            p = PH_PROCEEDING;
                            o.wire_a = WA_SEND;
                        end
                    end
                    else if (it.status_code < CODE_OK)
                    begin
                        if (early)
                        begin
                            p = PH_PROCEEDING;
                            o.wire_a = WA_SEND;
                        end
                    end
                    else if (it.status_code < CODE_FAIL)
                    begin
                        if (early)
                        begin
                            k = MK_STALE;
                            p = PH_TERMINATED;
                            arm(o, TK_STALE, 32'(ts));
                            o.wire_a = WA_SEND;
                        end
                    end
                    else if (early)
                    begin
                        p = PH_COMPLETED;
                        arm(o, TK_H, 64 * 32'(t1));
                        if (!reliable) arm(o, TK_G, 32'(t1));
                        o.wire_a = WA_SEND;
                    end
                end
            ACT_TIMER:
                case (it.timer_kind)
                    TK_G:
                        if (p == PH_COMPLETED)
                        begin
                            o.wire_a = WA_RESEND;
                            arm(o, TK_G, grow(32'(it.timer_delay)));
                        end
                    TK_H, TK_I: o.rel = 1'b1;
                    TK_J: ;
                    TK_TRYING: if (p == PH_TRYING) o.wire_a = WA_RESEND;
                    default: o.err = 1'b1;
                endcase
            default: ;
        endcase
    endfunction

    function automatic outcome_t predict_outcome(input item_t it);
        outcome_t    o;
        logic [2:0]  k, p, k0, p0;
        logic        have, created;
        o = '0;
        k = MK_CNI;
        p = PH_TERMINATED;
        k0 = MK_CNI;
        p0 = PH_TERMINATED;
        have = 1'b0;
        created = 1'b0;
        if (it.slot_known && ent_valid[it.slot])
        begin
            have = 1'b1;
            k = ent_kind[it.slot];
            p = ent_phase[it.slot];
            k0 = k;
            p0 = p;
            case (k)
                MK_CNI:   client_ni(o, p, it);
                MK_CI:    client_inv(o, k, p, it);
                MK_SNI:   server_ni(o, p, it);
                MK_SI:    server_inv(o, k, p, it);
                MK_STALE: if (it.action == ACT_TIMER && it.timer_kind == TK_STALE) o.rel = 1'b1;
                default:  o.err = 1'b1;
            endcase
        end
        else if (it.action == ACT_REQ)
        begin
            have = 1'b1;
            created = 1'b1;
            if (!it.from_user)
            begin
                if (it.method == M_INVITE)
                begin
                    k = MK_SI;
                    p = PH_PROCEEDING;
                    arm(o, TK_TRYING, 32'(t100));
                end
                else
                begin
                    k = MK_SNI;
                    p = PH_TRYING;
                end
                o.user_a = UA_PASS;
            end
            else if (it.method == M_INVITE)
            begin
                k = MK_CI;
                p = PH_CALLING;
                client_inv(o, k, p, it);
            end
            else
            begin
                k = MK_CNI;
                p = PH_TRYING;
                client_ni(o, p, it);
            end
        end
        else if (it.action == ACT_RESP && !discard) o.err = 1'b1;
        if (have)
        begin
            ent_kind[it.slot] = k;
            ent_phase[it.slot] = p;
            ent_valid[it.slot] = 1'b1;
            if (o.rel)
            begin
                ent_valid[it.slot] = 1'b0;
                ent_phase[it.slot] = PH_TERMINATED;
                p = PH_TERMINATED;
            end
        end
        o.drop = (o.wire_a == WA_NONE) && (o.user_a == UA_NONE) && (o.tk0 == 4'd0)
                 && !o.rel && !o.err && !created && k == k0 && p == p0;
        o.ph = have ? p : PH_TERMINATED;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want, got;
        item_t    it;
        if (!rst_n)
        begin
            t1 = 14'd500;
            t2 = 16'd4000;
            t4 = 16'd5000;
            td = 20'd32000;
            ts = 20'd32000;
            t100 = 16'd200;
            discard = 1'b1;
            reliable = 1'b0;
            for (int i = 0; i < 256; i++)
            begin
                ent_kind[i] = MK_CNI;
                ent_phase[i] = PH_CALLING;
                ent_valid[i] = 1'b0;
            end
            outcome_q.delete();
            fail_count = 0;
            awaited = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_T1:       t1 = cfg_data[13:0];
                    CFG_T2:       t2 = cfg_data[15:0];
                    CFG_T4:       t4 = cfg_data[15:0];
                    CFG_TD:       td = cfg_data;
                    CFG_TS:       ts = cfg_data;
                    CFG_T100:     t100 = cfg_data[15:0];
                    CFG_DISCARD:  discard = cfg_data[0];
                    CFG_RELIABLE: reliable = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = {wire_action, user_action, first_timer, first_delay, second_timer,
                       second_delay, release_slot, dropped, protocol_error, phase_after};
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result at %0t: %h", $realtime, got);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch at %0t: wire %0d/%0d user %0d/%0d ",
                                      "t0 %0d/%0d d0 %0d/%0d t1 %0d/%0d d1 %0d/%0d ",
                                      "rel %0d/%0d drop %0d/%0d err %0d/%0d ph %0d/%0d",
                                      " (expected/actual)"},
                                     $realtime, want.wire_a, got.wire_a,
                                     want.user_a, got.user_a, want.tk0, got.tk0,
                                     want.td0, got.td0, want.tk1, got.tk1,
                                     want.td1, got.td1, want.rel, got.rel,
                                     want.drop, got.drop, want.err, got.err,
                                     want.ph, got.ph);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                it = {action, slot, slot_known, method, cseq_method, status_code,
                      from_user, timer_kind, timer_delay};
                outcome_q.push_back(predict_outcome(it));
            end
            awaited = outcome_q.size();
        end
    end

endmodule

FILE: dv/tb_sip_transaction_fsm_table_core.sv
// ----------------------------------------------------------------------------
// tb_sip_transaction_fsm_table_core
// drives requests and configuration into the transaction table and gives the
// verdict; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_sip_transaction_fsm_table_core;
    import stft_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEMS_PER_PHASE = 520;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [19:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [7:0]  slot;
    logic        slot_known;
    logic [1:0]  method;
    logic [1:0]  cseq_method;
    logic [9:0]  status_code;
    logic        from_user;
    logic [3:0]  timer_kind;
    logic [19:0] timer_delay;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  wire_action;
    logic [1:0]  user_action;
    logic [3:0]  first_timer;
    logic [19:0] first_delay;
    logic [3:0]  second_timer;
    logic [19:0] second_delay;
    logic        release_slot;
    logic        dropped;
    logic        protocol_error;
    logic [2:0]  phase_after;

    int fail_count;
    int awaited;
    int cycles;
    int send_idle_pct;   // chance in a hundred that the sender idles instead of sending
    int recv_stall_pct;  // chance in a hundred that the result side stalls
    int sent;

    sip_transaction_fsm_table_core dut (.*);

    stft_result_checker checker_i (.*);

    // clock and the single reset at the start
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // watchdog: covers the clearing sweep after reset and the slowest phases
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[sip_transaction_fsm_table_core] ERROR");
            $finish;
        end
    end

    // result side back-pressure, redrawn every falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    function automatic item_t make_req(input logic [1:0] act, input logic [7:0] sl,
                                       input logic kn, input logic [1:0] meth,
                                       input logic [1:0] cs, input logic [9:0] code,
                                       input logic fu, input logic [3:0] tk,
                                       input logic [19:0] d);
        item_t it;
        it = {act, sl, kn, meth, cs, code, fu, tk, d};
        return it;
    endfunction

    // status codes around every boundary the machines look at
    function automatic logic [9:0] pick_code();
        case ($urandom_range(0, 11))
            0:  return CODE_PROV;
            1:  return 10'd180;
            2:  return 10'd199;
            3:  return CODE_OK;
            4:  return 10'd299;
            5:  return CODE_FAIL;
            6:  return 10'd486;
            7:  return CODE_MAX;
            8:  return 10'd700;
            9:  return 10'd99;
            10: return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [19:0] pick_delay();
        if ($urandom_range(0, 9) == 0) return 20'($urandom);
        return 20'($urandom_range(1, 20000));
    endfunction

    // fully random request, all fields and all bits free
    function automatic item_t noise_req(input logic [7:0] sl);
        return make_req(2'($urandom), sl, 1'($urandom), 2'($urandom), 2'($urandom),
                        10'($urandom), 1'($urandom), 4'($urandom_range(0, 15)),
                        20'($urandom));
    endfunction

    // request that opens a transaction of the given flavour
    // (0 client non-invite, 1 client invite, 2 server non-invite, 3 server invite)
    function automatic item_t opening_req(input int flavour, input logic [7:0] sl);
        logic kn;
        kn = ($urandom_range(0, 9) == 0);
        case (flavour)
            0: return make_req(ACT_REQ, sl, kn, 2'($urandom_range(1, 3)), 2'($urandom),
                               10'd0, 1'b1, TK_TRYING, 20'd0);
            1: return make_req(ACT_REQ, sl, kn, M_INVITE, M_INVITE, 10'd0, 1'b1,
                               TK_TRYING, 20'd0);
            2: return make_req(ACT_REQ, sl, kn, 2'($urandom_range(1, 3)), 2'($urandom),
                               10'd0, 1'b0, TK_TRYING, 20'd0);
            default: return make_req(ACT_REQ, sl, kn, M_INVITE, M_INVITE, 10'd0, 1'b0,
                                     TK_TRYING, 20'd0);
        endcase
    endfunction

    // follow-up fitting the flavour, with occasional strays
    function automatic item_t follow_req(input int flavour, input logic [7:0] sl);
        int pick;
        pick = $urandom_range(0, 3);
        if ($urandom_range(0, 99) < 15) return noise_req(sl);
        case (flavour)
            0:
                case (pick)
                    0, 1: return make_req(ACT_RESP, sl, 1'b1, M_INVITE, 2'd3, pick_code(),
                                          1'b0, TK_TRYING, 20'd0);
                    2: return make_req(ACT_TIMER, sl, 1'b1, M_INVITE, M_INVITE, 10'd0,
                                       1'b0, 4'($urandom_range(4, 6)), pick_delay());
                    default: return make_req(ACT_TIMER, sl, 1'b1, M_INVITE, M_INVITE,
                                             10'd0, 1'b0, TK_K, pick_delay());
                endcase
            1:
                case (pick)
                    0, 1: return make_req(ACT_RESP, sl, 1'b1, M_INVITE, M_INVITE,
                                          pick_code(), 1'b0, TK_TRYING, 20'd0);
                    2: return make_req(ACT_TIMER, sl, 1'b1, M_INVITE, M_INVITE, 10'd0,
                                       1'b0, TK_A, pick_delay());
                    default: return make_req(ACT_TIMER, sl, 1'b1, M_INVITE, M_INVITE,
                                             10'd0, 1'b0, 4'($urandom_range(1, 3)),
                                             pick_delay());
                endcase
            2:
                case (pick)
                    0: return make_req(ACT_REQ, sl, 1'b1, 2'($urandom_range(1, 3)),
                                       M_INVITE, 10'd0, 1'b0, TK_TRYING, 20'd0);
                    1, 2: return make_req(ACT_RESP, sl, 1'b1, M_INVITE, 2'($urandom),
                                          pick_code(), 1'b1, TK_TRYING, 20'd0);
                    default: return make_req(ACT_TIMER, sl, 1'b1, M_INVITE, M_INVITE,
                                             10'd0, 1'b0, TK_J, pick_delay());
                endcase
            default:
                case (pick)
                    0: return make_req(ACT_REQ, sl, 1'b1, 2'($urandom_range(0, 3)),
                                       M_INVITE, 10'd0, 1'b0, TK_TRYING, 20'd0);
                    1, 2: return make_req(ACT_RESP, sl, 1'b1, M_INVITE, M_INVITE,
                                          pick_code(), 1'b1, TK_TRYING, 20'd0);
                    default: return make_req(ACT_TIMER, sl, 1'b1, M_INVITE, M_INVITE,
                                             10'd0, 1'b0, 4'($urandom_range(7, 10)),
                                             pick_delay());
                endcase
        endcase
    endfunction

    // one request: optional idle cycles, then hold valid until taken.
    // entered and left on a falling edge; valid stays high on exit
    task automatic send_req(input item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        {action, slot, slot_known, method, cseq_method, status_code, from_user,
         timer_kind, timer_delay} = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic drain();
        in_valid = 1'b0;
        while (awaited != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [19:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_timers(input logic [13:0] v1, input logic [15:0] v2,
                               input logic [15:0] v4, input logic [19:0] vd,
                               input logic [19:0] vs, input logic [15:0] v100,
                               input logic disc, input logic rel);
        drain();
        write_reg(CFG_T1, 20'(v1));
        write_reg(CFG_T2, 20'(v2));
        write_reg(CFG_T4, 20'(v4));
        write_reg(CFG_TD, vd);
        write_reg(CFG_TS, vs);
        write_reg(CFG_T100, 20'(v100));
        write_reg(CFG_DISCARD, 20'(disc));
        write_reg(CFG_RELIABLE, 20'(rel));
    endtask

    // random transactions until the phase has sent its share
    task automatic random_phase();
        int          flavour, len, start;
        logic [7:0]  sl;
        start = sent;
        while (sent - start < ITEMS_PER_PHASE)
        begin
            flavour = $urandom_range(0, 4);
            sl = 8'($urandom);
            if (flavour == 4)
            begin
                send_req(noise_req(sl));
            end
            else
            begin
                send_req(opening_req(flavour, sl));
                len = $urandom_range(2, 6);
                repeat (len) send_req(follow_req(flavour, sl));
            end
        end
    endtask

    initial
    begin
        cycles = 0;
        sent = 0;
        cfg_valid = 1'b0;
        cfg_index = CFG_T1;
        cfg_data = '0;
        in_valid = 1'b0;
        {action, slot, slot_known, method, cseq_method, status_code, from_user,
         timer_kind, timer_delay} = '0;
        out_ready = 1'b0;
        send_idle_pct = 6;
        recv_stall_pct = 81;
        @(posedge rst_n);
        @(negedge clk);

        // directed part under reset settings
        // undefined action, timer with no entry, stray response
        send_req(make_req(2'd3, 8'd0, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_TRYING,
                          20'd0));
        send_req(make_req(ACT_TIMER, 8'd1, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_K,
                          20'd500));
        send_req(make_req(ACT_RESP, 8'd2, 1'b0, M_INVITE, M_INVITE, 10'd200, 1'b0,
                          TK_TRYING, 20'd0));
        // server invite: trying, provisional, failure, G backoff both sides of t2, ack, I
        send_req(make_req(ACT_REQ, 8'd10, 1'b0, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_TRYING,
                          20'd0));
        send_req(make_req(ACT_TIMER, 8'd10, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0,
                          TK_TRYING, 20'd200));
        send_req(make_req(ACT_RESP, 8'd10, 1'b1, M_INVITE, M_INVITE, 10'd180, 1'b1,
                          TK_TRYING, 20'd0));
        send_req(make_req(ACT_RESP, 8'd10, 1'b1, M_INVITE, M_INVITE, 10'd486, 1'b1,
                          TK_TRYING, 20'd0));
        send_req(make_req(ACT_TIMER, 8'd10, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_G,
                          20'd500));
        send_req(make_req(ACT_TIMER, 8'd10, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_G,
                          20'hFFFFF));
        send_req(make_req(ACT_REQ, 8'd10, 1'b1, M_ACK, M_INVITE, 10'd0, 1'b0, TK_TRYING,
                          20'd0));
        send_req(make_req(ACT_TIMER, 8'd10, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_I,
                          20'd5000));
        // client invite goes stale on 2xx; only the stale timer frees it
        send_req(make_req(ACT_REQ, 8'd20, 1'b0, M_INVITE, M_INVITE, 10'd0, 1'b1, TK_TRYING,
                          20'd0));
        send_req(make_req(ACT_RESP, 8'd20, 1'b1, M_INVITE, M_INVITE, 10'd100, 1'b0,
                          TK_TRYING, 20'd0));
        send_req(make_req(ACT_RESP, 8'd20, 1'b1, M_INVITE, M_INVITE, 10'd200, 1'b0,
                          TK_TRYING, 20'd0));
        send_req(make_req(ACT_TIMER, 8'd20, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_A,
                          20'd500));
        send_req(make_req(ACT_TIMER, 8'd20, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0,
                          TK_STALE, 20'd32000));
        // client non-invite: E1 restart, final response, K frees
        send_req(make_req(ACT_REQ, 8'd30, 1'b0, 2'd3, 2'd3, 10'd0, 1'b1, TK_TRYING, 20'd0));
        send_req(make_req(ACT_TIMER, 8'd30, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_E1,
                          20'd500));
        send_req(make_req(ACT_RESP, 8'd30, 1'b1, M_INVITE, 2'd3, 10'd200, 1'b0, TK_TRYING,
                          20'd0));
        send_req(make_req(ACT_TIMER, 8'd30, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_K,
                          20'd5000));
        // server non-invite on the top slot: cancel request, final, retransmit, J
        send_req(make_req(ACT_REQ, 8'd255, 1'b0, M_CANCEL, M_CANCEL, 10'd0, 1'b0,
                          TK_TRYING, 20'd0));
        send_req(make_req(ACT_RESP, 8'd255, 1'b1, M_INVITE, M_CANCEL, 10'd200, 1'b1,
                          TK_TRYING, 20'd0));
        send_req(make_req(ACT_REQ, 8'd255, 1'b1, M_CANCEL, M_CANCEL, 10'd0, 1'b0,
                          TK_TRYING, 20'd0));
        send_req(make_req(ACT_TIMER, 8'd255, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_J,
                          20'd32000));
        // timer B on a calling client invite: timeout flagged
        send_req(make_req(ACT_REQ, 8'd40, 1'b0, M_INVITE, M_INVITE, 10'd0, 1'b1, TK_TRYING,
                          20'd0));
        send_req(make_req(ACT_TIMER, 8'd40, 1'b1, M_INVITE, M_INVITE, 10'd0, 1'b0, TK_B,
                          20'd32000));

        // smallest settings, strays flagged, sender mostly busy, receiver mostly stalled
        load_timers(14'd1, 16'd1, 16'd1, 20'd1, 20'd1, 16'd1, 1'b0, 1'b0);
        random_phase();

        // largest settings on a reliable transport, roles swapped
        send_idle_pct = 81;
        recv_stall_pct = 6;
        load_timers(14'h3FFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF,
                    1'b1, 1'b1);
        random_phase();

        // random settings over the full range, no idling on either side
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_timers(14'($urandom_range(1, 16383)), 16'($urandom_range(1, 65535)),
                    16'($urandom_range(1, 65535)), 20'($urandom_range(1, 1048575)),
                    20'($urandom_range(1, 1048575)), 16'($urandom_range(1, 65535)),
                    1'($urandom), 1'($urandom));
        random_phase();

        drain();
        if (fail_count == 0)
            $display("[sip_transaction_fsm_table_core] OK");
        else
            $display("[sip_transaction_fsm_table_core] ERROR");
        $finish;
    end

endmodule
